// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the leaky conveyor delay line.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that an expression holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion violated");

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion violated");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)

`endif

`endif

// ----- hw/rtl/lcd_pkg.sv -----
// Package of the leaky conveyor delay line: sizes, codes, types and helpers.
// No dependencies; used by lcd_ring and leaky_conveyor_delay.
package lcd_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int QTY_W  = 32;
   localparam int TIME_W = 48;
   localparam int POP_W  = 38;
   localparam int RATE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TIME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_RELEASE
   } state_type;

   typedef struct packed {
      logic               q_en;
      logic               t_en;
      logic [IDX_W-1:0]   addr;
      logic [QTY_W-1:0]   quantity;
      logic [TIME_W-1:0]  release_time;
   } ring_wr_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [TIME_W-1:0] time_sat_add(input logic [TIME_W-1:0] a,
                                                      input logic [QTY_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + (TIME_W + 1)'(b);
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   function automatic logic [POP_W-1:0] pop_sub(input logic [POP_W-1:0] pop,
                                                input logic [QTY_W-1:0] v);
      return (POP_W'(v) > pop) ? '0 : pop - POP_W'(v);
   endfunction

endpackage

// ----- hw/rtl/lcd_ring.sv -----
// Ring storage of the leaky conveyor delay line: quantity and release time memories.
// One write port and one registered read port; depends on lcd_pkg.
module lcd_ring (
   input  logic                        clock,
   input  lcd_pkg::ring_wr_type        wr,
   input  logic [lcd_pkg::IDX_W-1:0]   rd_addr,
   output logic [lcd_pkg::QTY_W-1:0]   rd_quantity,
   output logic [lcd_pkg::TIME_W-1:0]  rd_release_time
);
   import lcd_pkg::*;

   logic [QTY_W-1:0]  quantity_mem [DEPTH];
   logic [TIME_W-1:0] release_mem  [DEPTH];
   logic [QTY_W-1:0]  rd_quantity_ff;
   logic [TIME_W-1:0] rd_release_ff;

   always_ff @(posedge clock) begin
      if (wr.q_en) begin
         quantity_mem[wr.addr] <= wr.quantity;
      end
      if (wr.t_en) begin
         release_mem[wr.addr] <= wr.release_time;
      end
      rd_quantity_ff <= quantity_mem[rd_addr];
      rd_release_ff  <= release_mem[rd_addr];
   end

   assign rd_quantity     = rd_quantity_ff;
   assign rd_release_time = rd_release_ff;

endmodule

// ----- hw/rtl/leaky_conveyor_delay.sv -----
// Top level of the leaky conveyor delay line: sequencer, leak pipeline and state.
// Depends on lcd_pkg, lcd_ring and assert_macros.svh.
//
//   port group   direction  handshake                 payload
//   req_         in         start high, busy low      cmd, influx_value, time_step
//   rsp_         out        rsp_valid for one cycle   released_sum, population, full_error
//   csr_         in         csr_write_enable          csr_index, csr_write_data
//
// Add, no-op and a dropped add keep busy low; the result follows in the cycle after start.
// A tick holds busy, also on an empty ring, while one 32x32 multiplier leaks one entry
// per cycle through a read, multiply and write-back pipeline.
// A release holds busy while it takes due entries from the head, and while it checks
// the first entry left waiting; a release on an empty ring keeps busy low.
// Reset is synchronous and clears the control state; the ring memories are not cleared.
// The receiver cannot stall, so every result is shown for exactly one cycle.
`include "assert_macros.svh"

module leaky_conveyor_delay (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_cmd,
   input  logic [lcd_pkg::QTY_W-1:0]       req_influx_value,
   input  logic [lcd_pkg::QTY_W-1:0]       req_time_step,
   output logic                            rsp_valid,
   output logic [lcd_pkg::POP_W-1:0]       rsp_released_sum,
   output logic [lcd_pkg::POP_W-1:0]       rsp_population,
   output logic                            rsp_full_error,
   input  logic                            csr_write_enable,
   input  logic [lcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lcd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import lcd_pkg::*;

   state_type          state_ff, state_in;
   logic [QTY_W-1:0]   delay_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POP_W-1:0]   pop_ff, pop_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TIME_W-1:0]  factor_ff, factor_in;
   logic [QTY_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [CNT_W-1:0]   issued_ff, issued_in;
   logic               v1_ff, v1_in;
   logic [IDX_W-1:0]   a1_ff;
   logic               v2_ff;
   logic [IDX_W-1:0]   a2_ff;
   logic [QTY_W-1:0]   q2_ff;
   logic [2*QTY_W-1:0] prod_ff, prod_in;
   logic [POP_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POP_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [POP_W-1:0]   rsp_pop_ff, rsp_pop_in;
   logic               rsp_full_ff, rsp_full_in;

   logic               accept;
   cmd_type            cmd;
   logic               sweep_done;
   logic               rel_take;
   logic               rel_finish;
   logic [IDX_W-1:0]   rd_addr;
   logic [QTY_W-1:0]   rd_quantity;
   logic [TIME_W-1:0]  rd_release_time;
   logic [QTY_W-1:0]   leak;
   ring_wr_type        ring_wr;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_cmd);

   assign sweep_done = (state_ff == ST_SWEEP) && (issued_ff == count_ff) && !v1_ff && !v2_ff;
   assign rel_take   = (rd_release_time <= time_ff);
   assign rel_finish = (state_ff == ST_RELEASE) &&
                       (!rel_take || (count_ff == CNT_W'(1)));

   // A factor of one or more drains every entry completely.
   assign leak = (factor_ff[TIME_W-1:QTY_W] != '0) ? q2_ff : prod_ff[2*QTY_W-1:QTY_W];

   lcd_ring u_ring (
      .clock           (clock),
      .wr              (ring_wr),
      .rd_addr         (rd_addr),
      .rd_quantity     (rd_quantity),
      .rd_release_time (rd_release_time)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_TICK)) begin
               state_in = ST_SWEEP;
            end else if (accept && (cmd == CMD_RELEASE) && (count_ff != '0)) begin
               state_in = ST_RELEASE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            if (rel_finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      pop_in        = pop_ff;
      time_in       = time_ff;
      factor_in     = factor_ff;
      step_in       = step_ff;
      sweep_addr_in = sweep_addr_ff;
      issued_in     = issued_ff;
      v1_in         = 1'b0;
      sum_in        = sum_ff;
      rsp_valid_in  = 1'b0;
      rsp_sum_in    = '0;
      rsp_pop_in    = pop_ff;
      rsp_full_in   = 1'b0;
      rd_addr       = rd_idx_ff;
      prod_in       = rd_quantity * factor_ff[QTY_W-1:0];
      ring_wr       = '{q_en: 1'b0, t_en: 1'b0, addr: wr_idx_ff, quantity: req_influx_value,
                        release_time: time_sat_add(time_ff, delay_ff)};

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = rd_idx_ff;
            if (accept) begin
               unique case (cmd)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        ring_wr.q_en = 1'b1;
                        ring_wr.t_en = 1'b1;
                        pop_in       = pop_ff + POP_W'(req_influx_value);
                        count_in     = count_ff + CNT_W'(1);
                        wr_idx_in    = idx_inc(wr_idx_ff);
                        rsp_pop_in   = pop_in;
                     end
                  end
                  CMD_TICK: begin
                     factor_in     = TIME_W'(rate_ff) * TIME_W'(req_time_step);
                     step_in       = req_time_step;
                     v1_in         = (count_ff != '0);
                     issued_in     = (count_ff != '0) ? CNT_W'(1) : '0;
                     sweep_addr_in = idx_inc(rd_idx_ff);
                  end
                  CMD_RELEASE: begin
                     sum_in = '0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SWEEP: begin
            rd_addr = sweep_addr_ff;
            if (issued_ff < count_ff) begin
               v1_in         = 1'b1;
               issued_in     = issued_ff + CNT_W'(1);
               sweep_addr_in = idx_inc(sweep_addr_ff);
            end
            if (v2_ff) begin
               ring_wr.q_en     = 1'b1;
               ring_wr.addr     = a2_ff;
               ring_wr.quantity = q2_ff - leak;
               pop_in           = pop_sub(pop_ff, leak);
            end
            if (sweep_done) begin
               time_in      = time_sat_add(time_ff, step_ff);
               rsp_valid_in = 1'b1;
            end
         end
         ST_RELEASE: begin
            // Fetch the next entry speculatively while the current one is checked.
            rd_addr = idx_inc(rd_idx_ff);
            if (rel_take) begin
               sum_in    = sum_ff + POP_W'(rd_quantity);
               pop_in    = pop_sub(pop_ff, rd_quantity);
               count_in  = count_ff - CNT_W'(1);
               rd_idx_in = idx_inc(rd_idx_ff);
            end
            if (rel_finish) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_in;
               rsp_pop_in   = pop_in;
            end
         end
         default: rd_addr = rd_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= '0;
         rate_ff      <= '0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         pop_ff       <= '0;
         time_ff      <= '0;
         issued_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         pop_ff       <= pop_in;
         time_ff      <= time_in;
         issued_ff    <= issued_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == CSR_DELAY_TIME)) begin
            delay_ff <= csr_write_data[QTY_W-1:0];
         end
         if (csr_write_enable && (csr_index == CSR_DECAY_RATE)) begin
            rate_ff <= csr_write_data[RATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      factor_ff     <= factor_in;
      step_ff       <= step_in;
      sweep_addr_ff <= sweep_addr_in;
      a1_ff         <= rd_addr;
      a2_ff         <= a1_ff;
      q2_ff         <= rd_quantity;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_released_sum = rsp_sum_ff;
   assign rsp_population   = rsp_pop_ff;
   assign rsp_full_error   = rsp_full_ff;

   `ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CNT_W'(DEPTH))
   `ASSERT_IMPLIES(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `ASSERT_IMPLIES(a_full_keeps_pop, clock, reset, rsp_valid_ff && rsp_full_ff,
                   $stable(pop_ff) && $stable(count_ff))
   `ASSERT_IMPLIES(a_sweep_issue_bounded, clock, reset, state_ff == ST_SWEEP,
                   issued_ff <= count_ff)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for leaky_conveyor_delay: directed table and random phases.
// Depends on lcd_pkg and the leaky_conveyor_delay RTL; every result is checked against a
// typed-in value or a bit-exact prediction kept inside this file.
module testbench;
   import lcd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 210;
   localparam logic [TIME_W-1:0] TIME_CEIL = {TIME_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   typedef struct packed {
      logic [POP_W-1:0] released_sum;
      logic [POP_W-1:0] population;
      logic             full_error;
   } conveyor_result_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      cmd_type             cmd;
      logic [31:0]         arg_a;
      logic [31:0]         arg_b;
      bit                  typed;
      conveyor_result_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_cmd = CMD_NOP;
   logic [QTY_W-1:0]      req_influx_value = '0;
   logic [QTY_W-1:0]      req_time_step = '0;
   logic                  rsp_valid;
   logic [POP_W-1:0]      rsp_released_sum;
   logic [POP_W-1:0]      rsp_population;
   logic                  rsp_full_error;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Predicted contents of the conveyor.
   logic [QTY_W-1:0]  ring_qty [DEPTH];
   logic [TIME_W-1:0] ring_due [DEPTH];
   int unsigned       head_idx = 0;
   int unsigned       tail_idx = 0;
   int unsigned       stored = 0;
   logic [POP_W-1:0]  pop_total = '0;
   logic [TIME_W-1:0] now_time = '0;
   logic [QTY_W-1:0]  transit_time = '0;
   logic [RATE_W-1:0] leak_rate = '0;

   conveyor_result_type expected_results [$];
   stim_row_type        directed_rows [$];
   int                  error_count = 0;
   int                  results_seen = 0;
   int                  cycle_count = 0;
   bit                  idle_on = 1'b1;

   leaky_conveyor_delay dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_influx_value (req_influx_value),
      .req_time_step    (req_time_step),
      .rsp_valid        (rsp_valid),
      .rsp_released_sum (rsp_released_sum),
      .rsp_population   (rsp_population),
      .rsp_full_error   (rsp_full_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [TIME_W-1:0] clamp_time_add(input logic [TIME_W-1:0] a,
                                                        input logic [QTY_W-1:0] b);
      logic [TIME_W:0] total;
      total = (TIME_W + 1)'(a) + (TIME_W + 1)'(b);
      return (total > (TIME_W + 1)'(TIME_CEIL)) ? TIME_CEIL : total[TIME_W-1:0];
   endfunction

   function automatic void drain_population(input logic [63:0] amount);
      pop_total = (amount > 64'(pop_total)) ? '0 : pop_total - POP_W'(amount);
   endfunction

   task automatic predict_conveyor(input cmd_type c, input logic [QTY_W-1:0] influx,
                                   input logic [QTY_W-1:0] step,
                                   output conveyor_result_type res);
      logic [TIME_W-1:0] factor;
      logic [63:0]       leak;
      logic [POP_W-1:0]  released;
      int unsigned       idx;
      released = '0;
      res.full_error = 1'b0;
      case (c)
         CMD_ADD: begin
            if (stored >= DEPTH) begin
               res.full_error = 1'b1;
            end else begin
               ring_qty[tail_idx] = influx;
               ring_due[tail_idx] = clamp_time_add(now_time, transit_time);
               pop_total = pop_total + POP_W'(influx);
               stored++;
               tail_idx = (tail_idx + 1) % DEPTH;
            end
         end
         CMD_TICK: begin
            factor = TIME_W'(leak_rate) * TIME_W'(step);
            idx = head_idx;
            for (int n = 0; n < stored; n++) begin
               // A factor of one or more wipes the entry out completely.
               if (factor >= TIME_W'(64'h1_0000_0000))
                  leak = 64'(ring_qty[idx]);
               else
                  leak = (64'(ring_qty[idx]) * 64'(factor)) >> 32;
               ring_qty[idx] = ring_qty[idx] - leak[QTY_W-1:0];
               drain_population(leak);
               idx = (idx + 1) % DEPTH;
            end
            now_time = clamp_time_add(now_time, step);
         end
         CMD_RELEASE: begin
            while (stored > 0 && ring_due[head_idx] <= now_time) begin
               released = released + POP_W'(ring_qty[head_idx]);
               drain_population(64'(ring_qty[head_idx]));
               stored--;
               head_idx = (head_idx + 1) % DEPTH;
            end
         end
         default: ;
      endcase
      res.released_sum = released;
      res.population = pop_total;
   endtask

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      conveyor_result_type exp_res;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with no transaction pending",
                                    results_seen));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_released_sum !== exp_res.released_sum)
               flag_mismatch($sformatf("result %0d released_sum %h, want %h", results_seen,
                                       rsp_released_sum, exp_res.released_sum));
            if (rsp_population !== exp_res.population)
               flag_mismatch($sformatf("result %0d population %h, want %h", results_seen,
                                       rsp_population, exp_res.population));
            if (rsp_full_error !== exp_res.full_error)
               flag_mismatch($sformatf("result %0d full_error %b, want %b", results_seen,
                                       rsp_full_error, exp_res.full_error));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("leaky_conveyor_delay regression: fail");
      $finish;
   end

   // Presents one transaction, holds it until busy is low at an edge, then records the
   // expected result (typed-in where the row gives one, predicted otherwise).
   task automatic drive_item(input cmd_type c, input logic [QTY_W-1:0] influx,
                             input logic [QTY_W-1:0] step, input bit typed,
                             input conveyor_result_type typed_res);
      conveyor_result_type pred;
      if (idle_on && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_influx_value <= influx;
      req_time_step <= step;
      do @(posedge clock); while (busy);
      predict_conveyor(c, influx, step, pred);
      expected_results.push_back(typed ? typed_res : pred);
   endtask

   task automatic wait_until_quiet();
      start <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == CSR_DELAY_TIME)
         transit_time = data;
      else if (idx == CSR_DECAY_RATE)
         leak_rate = data[RATE_W-1:0];
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item(input int add_weight);
      int          pick;
      cmd_type     c;
      logic [31:0] influx;
      logic [31:0] step;
      pick = $urandom_range(0, 99);
      if (pick < add_weight)
         c = CMD_ADD;
      else if (pick < add_weight + 28)
         c = CMD_TICK;
      else if (pick < 95)
         c = CMD_RELEASE;
      else
         c = CMD_NOP;
      pick = $urandom_range(0, 19);
      influx = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         step = 32'h0;
      else if (pick == 1)
         step = 32'hFFFF_FFFF;
      else if (pick < 10)
         step = $urandom_range(0, 32'h0001_FFFF);
      else
         step = $urandom;
      drive_item(c, influx, step, 1'b0, '0);
   endtask

   function automatic void plain_row(input cmd_type c, input logic [31:0] a,
                                     input logic [31:0] b);
      directed_rows.push_back('{ROW_ITEM, c, a, b, 1'b0, '0});
   endfunction

   function automatic void typed_row(input cmd_type c, input logic [31:0] a,
                                     input logic [31:0] b, input logic [POP_W-1:0] sum,
                                     input logic [POP_W-1:0] pop, input logic full);
      conveyor_result_type want;
      want.released_sum = sum;
      want.population = pop;
      want.full_error = full;
      directed_rows.push_back('{ROW_ITEM, c, a, b, 1'b1, want});
   endfunction

   function automatic void csr_row(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      directed_rows.push_back('{ROW_CSR, CMD_NOP, 32'(idx), data, 1'b0, '0});
   endfunction

   initial begin
      logic [31:0] delay_val;
      logic [31:0] rate_word;
      int          add_weight;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Right after reset both registers are zero, so these results are plain to see.
      typed_row(CMD_RELEASE, 32'h0, 32'h0, '0, '0, 1'b0);
      typed_row(CMD_TICK, 32'h0, 32'hFFFF_FFFF, '0, '0, 1'b0);
      typed_row(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 1'b0);
      typed_row(CMD_ADD, 32'hFFFF_FFFF, 32'h0, '0, POP_W'(32'hFFFF_FFFF), 1'b0);
      typed_row(CMD_ADD, 32'h0, 32'hFFFF_FFFF, '0, POP_W'(32'hFFFF_FFFF), 1'b0);
      typed_row(CMD_TICK, 32'h0, 32'hFFFF_FFFF, '0, POP_W'(32'hFFFF_FFFF), 1'b0);
      typed_row(CMD_RELEASE, 32'h0, 32'h0, POP_W'(32'hFFFF_FFFF), '0, 1'b0);
      csr_row(CSR_DECAY_RATE, 32'hFFFF_FFFF);
      csr_row(CSR_DELAY_TIME, 32'h0001_0000);
      plain_row(CMD_ADD, 32'h0001_0000, 32'h0);
      plain_row(CMD_ADD, 32'hFFFF_FFFF, 32'h0);
      plain_row(CMD_TICK, 32'h0, 32'h0000_0001);
      plain_row(CMD_TICK, 32'h0, 32'h0000_8000);
      plain_row(CMD_RELEASE, 32'h0, 32'h0);
      // Leak factor just below one, then just above it.
      plain_row(CMD_TICK, 32'h0, 32'h0001_0001);
      plain_row(CMD_TICK, 32'h0, 32'h0001_0002);
      plain_row(CMD_RELEASE, 32'h0, 32'h0);
      csr_row(CSR_DELAY_TIME, 32'hFFFF_FFFF);
      plain_row(CMD_ADD, 32'h1234_5678, 32'h0);
      plain_row(CMD_RELEASE, 32'h0, 32'h0);
      plain_row(CMD_TICK, 32'h0, 32'hFFFF_FFFF);
      plain_row(CMD_RELEASE, 32'h0, 32'h0);
      // Writes to unused register indexes must leave both registers alone.
      csr_row(CSR_SPARE_LO, 32'hFFFF_FFFF);
      csr_row(CSR_SPARE_HI, 32'h0);
      plain_row(CMD_TICK, 32'h0, 32'h0000_4000);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_until_quiet();
            write_register(directed_rows[i].arg_a[CSR_IDX_W-1:0], directed_rows[i].arg_b);
         end else begin
            drive_item(directed_rows[i].cmd, directed_rows[i].arg_a, directed_rows[i].arg_b,
                       directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Overfill the ring so that the last add is dropped as full.
      for (int i = 0; i <= DEPTH; i++)
         drive_item(CMD_ADD, $urandom, 32'h0, 1'b0, '0);
      drive_item(CMD_RELEASE, 32'h0, 32'h0, 1'b0, '0);

      for (int phase = 0; phase < 5; phase++) begin
         wait_until_quiet();
         case (phase)
            0: delay_val = 32'h0;
            1: delay_val = 32'hFFFF_FFFF;
            2: delay_val = $urandom_range(0, 32'h000F_FFFF);
            3: delay_val = $urandom;
            default: delay_val = $urandom_range(0, 32'h0003_0000);
         endcase
         rate_word = $urandom;
         if (phase == 0)
            rate_word[RATE_W-1:0] = '0;
         else if (phase == 1)
            rate_word[RATE_W-1:0] = '1;
         else if (phase == 4)
            rate_word[RATE_W-1:0] = RATE_W'($urandom_range(1, 255));
         write_register(CSR_DELAY_TIME, delay_val);
         write_register(CSR_DECAY_RATE, rate_word);
         write_register(phase[0] ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         idle_on = (phase != 2);
         add_weight = (phase == 1 || phase == 4) ? 50 : 35;
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(add_weight);
      end

      // One long tick and a release empty the ring before the closing random run.
      wait_until_quiet();
      write_register(CSR_DELAY_TIME, 32'hFFFF_FFFF);
      write_register(CSR_DECAY_RATE, $urandom);
      drive_item(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
      drive_item(CMD_RELEASE, 32'h0, 32'h0, 1'b0, '0);
      for (int i = 0; i < 100; i++)
         random_item(40);

      start <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("leaky_conveyor_delay regression: pass");
      else
         $display("leaky_conveyor_delay regression: fail");
      $finish;
   end

endmodule
